// ===== hdl/i2cbe_pkg.sv =====
// Package with the shared types, codes and constants of the I2C master bit engine.
package i2cbe_pkg;

	localparam int unsigned DataW = 8;
	localparam int unsigned BitCntW = 4;
	localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

	localparam logic [DataW-1:0] ShortDelayRst = 8'd2;
	localparam logic [DataW-1:0] LongDelayRst = 8'd4;
	localparam logic [DataW-1:0] SampleHoldRst = 8'd1;
	localparam logic [DataW-1:0] AckTimeoutRst = 8'd250;

	localparam logic [2:0] OpReserved = 3'd7;

	typedef enum logic [1:0] {
		REG_SHORT_DELAY = 2'd0,
		REG_LONG_DELAY = 2'd1,
		REG_SAMPLE_HOLD = 2'd2,
		REG_ACK_TIMEOUT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ = 3'd3,
		OP_ACK = 3'd4,
		OP_NACK = 3'd5,
		OP_WAIT_ACK = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_STA1 = 4'd1,
		PH_STA2 = 4'd2,
		PH_STO1 = 4'd3,
		PH_STO2 = 4'd4,
		PH_STO3 = 4'd5,
		PH_POLL = 4'd6,
		PH_WAEND = 4'd7,
		PH_AK1 = 4'd8,
		PH_AK2 = 4'd9,
		PH_WRHI = 4'd10,
		PH_WRLO = 4'd11,
		PH_WRNEXT = 4'd12,
		PH_RDHI = 4'd13,
		PH_RDNEXT = 4'd14
	} phase_t;

	typedef struct packed {
		logic [DataW-1:0] short_delay;
		logic [DataW-1:0] long_delay;
		logic [DataW-1:0] sample_hold;
		logic [DataW-1:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic cmd_ok;
		logic [2:0] opcode;
		logic [DataW-1:0] tx_byte;
		logic sda_in;
	} item_t;

	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic sda_drive;
		logic busy_res;
		logic done_res;
		logic [DataW-1:0] rx_byte;
		logic ack_missing;
	} res_t;

	function automatic logic [DataW-1:0] delay_min1(input logic [DataW-1:0] d);
		delay_min1 = (d == '0) ? {{(DataW-1){1'b0}}, 1'b1} : d;
	endfunction

endpackage

// ===== hdl/i2cbe_if.sv =====
// Interfaces of the command channel and the result channel.
interface i2cbe_cmd_if import i2cbe_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd_valid;
	logic [2:0] opcode;
	logic [DataW-1:0] tx_byte;
	logic sda_in;

	modport source (output valid, cmd_valid, opcode, tx_byte, sda_in, input ready);
	modport sink (input valid, cmd_valid, opcode, tx_byte, sda_in, output ready);
endinterface

interface i2cbe_res_if import i2cbe_pkg::*; ();
	logic valid;
	logic ready;
	logic scl_level;
	logic sda_level;
	logic sda_drive;
	logic busy_res;
	logic done_res;
	logic [DataW-1:0] rx_byte;
	logic ack_missing;

	modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_missing, input ready);
	modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		rx_byte, ack_missing, output ready);
endinterface

// ===== hdl/i2cbe_front.sv =====
// Front end: accepts ticks, classifies the command and queues them for the engine.
module i2cbe_front import i2cbe_pkg::*; (
	input logic clk,
	input logic arst_n,
	i2cbe_cmd_if.sink cmd,
	output item_t item,
	output logic item_avail,
	input logic item_take
);

	item_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	item_t classified;

	always_comb begin
		classified.cmd_ok = cmd.cmd_valid && (cmd.opcode != OpReserved);
		classified.opcode = cmd.opcode;
		classified.tx_byte = cmd.tx_byte;
		classified.sda_in = cmd.sda_in;
	end

	assign cmd.ready = (count_q != 2'd2);
	assign push = cmd.valid && cmd.ready;
	assign item_avail = (count_q != 2'd0);
	assign item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, item_take};
		end
	end

endmodule

// ===== hdl/i2cbe_engine.sv =====
// Back end: the bus sequencer that runs one tick per item and buffers the results.
module i2cbe_engine import i2cbe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input item_t item,
	input logic item_avail,
	output logic item_take,
	i2cbe_res_if.source res
);

	phase_t phase_q, phase_nxt;
	logic [DataW-1:0] delay_q, delay_nxt;
	logic [BitCntW-1:0] bit_q, bit_nxt;
	logic [DataW-1:0] shift_q, shift_nxt;
	logic [DataW-1:0] timeout_q, timeout_nxt;
	logic scl_q, scl_nxt;
	logic sda_q, sda_nxt;
	logic dir_q, dir_nxt;
	logic [DataW-1:0] rx_q, rx_nxt;
	logic err_q, err_nxt;
	logic done;
	logic run_act;

	res_t res_q [2];
	logic res_wr_q;
	logic res_rd_q;
	logic [1:0] res_cnt_q;
	logic res_pop;
	res_t res_new;

	assign item_take = item_avail && (res_cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			delay_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			timeout_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			dir_q <= 1'b1;
			rx_q <= '0;
			err_q <= 1'b0;
		end else if (item_take) begin
			phase_q <= phase_nxt;
			delay_q <= delay_nxt;
			bit_q <= bit_nxt;
			shift_q <= shift_nxt;
			timeout_q <= timeout_nxt;
			scl_q <= scl_nxt;
			sda_q <= sda_nxt;
			dir_q <= dir_nxt;
			rx_q <= rx_nxt;
			err_q <= err_nxt;
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		delay_nxt = delay_q;
		bit_nxt = bit_q;
		shift_nxt = shift_q;
		timeout_nxt = timeout_q;
		scl_nxt = scl_q;
		sda_nxt = sda_q;
		dir_nxt = dir_q;
		rx_nxt = rx_q;
		err_nxt = err_q;
		done = 1'b0;
		run_act = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item.cmd_ok) begin
				bit_nxt = '0;
				case (op_t'(item.opcode))
					OP_START: begin
						dir_nxt = 1'b1;
						scl_nxt = 1'b1;
						sda_nxt = 1'b1;
						delay_nxt = delay_min1(cfg.long_delay);
						phase_nxt = PH_STA1;
					end
					OP_STOP: begin
						dir_nxt = 1'b1;
						sda_nxt = 1'b0;
						delay_nxt = delay_min1(cfg.long_delay);
						phase_nxt = PH_STO1;
					end
					OP_WRITE: begin
						dir_nxt = 1'b1;
						scl_nxt = 1'b0;
						sda_nxt = item.tx_byte[DataW-1];
						shift_nxt = {item.tx_byte[DataW-2:0], 1'b0};
						bit_nxt = {{(BitCntW-1){1'b0}}, 1'b1};
						delay_nxt = delay_min1(cfg.short_delay);
						phase_nxt = PH_WRHI;
					end
					OP_READ: begin
						dir_nxt = 1'b0;
						shift_nxt = '0;
						scl_nxt = 1'b0;
						delay_nxt = delay_min1(cfg.short_delay);
						phase_nxt = PH_RDHI;
					end
					OP_ACK, OP_NACK: begin
						scl_nxt = 1'b0;
						dir_nxt = 1'b1;
						sda_nxt = (op_t'(item.opcode) == OP_NACK);
						delay_nxt = delay_min1(cfg.short_delay);
						phase_nxt = PH_AK1;
					end
					OP_WAIT_ACK: begin
						dir_nxt = 1'b0;
						scl_nxt = 1'b1;
						timeout_nxt = '0;
						err_nxt = 1'b0;
						delay_nxt = delay_min1(cfg.short_delay);
						phase_nxt = PH_POLL;
					end
					default: begin
						phase_nxt = PH_IDLE;
					end
				endcase
			end
		end else if (phase_q == PH_POLL) begin
			run_act = 1'b1;
		end else if (delay_q > 8'd1) begin
			delay_nxt = delay_q - 8'd1;
		end else begin
			delay_nxt = '0;
			run_act = 1'b1;
		end

		if (run_act) begin
			case (phase_q)
				PH_STA1: begin
					sda_nxt = 1'b0;
					delay_nxt = delay_min1(cfg.long_delay);
					phase_nxt = PH_STA2;
				end
				PH_STA2: begin
					scl_nxt = 1'b0;
					done = 1'b1;
				end
				PH_STO1: begin
					scl_nxt = 1'b1;
					delay_nxt = delay_min1(cfg.long_delay);
					phase_nxt = PH_STO2;
				end
				PH_STO2: begin
					sda_nxt = 1'b1;
					delay_nxt = delay_min1(cfg.long_delay);
					phase_nxt = PH_STO3;
				end
				PH_POLL: begin
					if (!item.sda_in) begin
						scl_nxt = 1'b0;
						delay_nxt = delay_min1(cfg.short_delay);
						phase_nxt = PH_WAEND;
					end else if (timeout_q >= cfg.ack_timeout) begin
						err_nxt = 1'b1;
						dir_nxt = 1'b1;
						sda_nxt = 1'b0;
						delay_nxt = delay_min1(cfg.long_delay);
						phase_nxt = PH_STO1;
					end else begin
						timeout_nxt = timeout_q + 8'd1;
					end
				end
				PH_AK1: begin
					scl_nxt = 1'b1;
					delay_nxt = delay_min1(cfg.short_delay);
					phase_nxt = PH_AK2;
				end
				PH_AK2: begin
					scl_nxt = 1'b0;
					done = 1'b1;
				end
				PH_WRHI: begin
					scl_nxt = 1'b1;
					delay_nxt = delay_min1(cfg.short_delay);
					phase_nxt = PH_WRLO;
				end
				PH_WRLO: begin
					scl_nxt = 1'b0;
					delay_nxt = delay_min1(cfg.short_delay);
					phase_nxt = PH_WRNEXT;
				end
				PH_WRNEXT: begin
					if (bit_q >= BitsPerByte) begin
						done = 1'b1;
					end else begin
						sda_nxt = shift_q[DataW-1];
						shift_nxt = {shift_q[DataW-2:0], 1'b0};
						bit_nxt = bit_q + 4'd1;
						delay_nxt = delay_min1(cfg.short_delay);
						phase_nxt = PH_WRHI;
					end
				end
				PH_RDHI: begin
					scl_nxt = 1'b1;
					shift_nxt = {shift_q[DataW-2:0], item.sda_in};
					bit_nxt = bit_q + 4'd1;
					delay_nxt = delay_min1(cfg.sample_hold);
					phase_nxt = PH_RDNEXT;
				end
				PH_RDNEXT: begin
					if (bit_q >= BitsPerByte) begin
						rx_nxt = shift_q;
						done = 1'b1;
					end else begin
						scl_nxt = 1'b0;
						delay_nxt = delay_min1(cfg.short_delay);
						phase_nxt = PH_RDHI;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end

		if (done) begin
			phase_nxt = PH_IDLE;
		end

		res_new.scl_level = scl_nxt;
		res_new.sda_level = sda_nxt;
		res_new.sda_drive = dir_nxt;
		res_new.busy_res = (phase_nxt != PH_IDLE);
		res_new.done_res = done;
		res_new.rx_byte = rx_nxt;
		res_new.ack_missing = err_nxt;
	end

	assign res.valid = (res_cnt_q != 2'd0);
	assign res_pop = res.valid && res.ready;
	assign res.scl_level = res_q[res_rd_q].scl_level;
	assign res.sda_level = res_q[res_rd_q].sda_level;
	assign res.sda_drive = res_q[res_rd_q].sda_drive;
	assign res.busy_res = res_q[res_rd_q].busy_res;
	assign res.done_res = res_q[res_rd_q].done_res;
	assign res.rx_byte = res_q[res_rd_q].rx_byte;
	assign res.ack_missing = res_q[res_rd_q].ack_missing;

	always_ff @(posedge clk) begin
		if (item_take) begin
			res_q[res_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q <= 1'b0;
			res_rd_q <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (item_take) begin
				res_wr_q <= ~res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= ~res_rd_q;
			end
			res_cnt_q <= res_cnt_q + {1'b0, item_take} - {1'b0, res_pop};
		end
	end

endmodule

// ===== hdl/i2c_master_bit_engine_unit.sv =====
// Top level of the I2C master bit engine with its configuration registers.
// Each transfer on the command channel is one bus tick and yields exactly one transfer on
// the result channel with the SCL and SDA levels in force after that tick. The block takes
// one tick per clock cycle while cmd.ready is high; a tick passes a two-entry input queue
// and then the sequencer, whose result is registered in a two-entry output buffer. Either
// queue lets its side stall without stopping the other until it fills. The user must write
// configuration registers only while no tick is in flight; the block does not enforce it.
module i2c_master_bit_engine_unit import i2cbe_pkg::*; (
	input logic clk,
	input logic arst_n,
	i2cbe_cmd_if.sink cmd,
	i2cbe_res_if.source res,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [DataW-1:0] cfg_data
);

	cfg_t cfg_q;
	item_t item;
	logic item_avail;
	logic item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_delay <= ShortDelayRst;
			cfg_q.long_delay <= LongDelayRst;
			cfg_q.sample_hold <= SampleHoldRst;
			cfg_q.ack_timeout <= AckTimeoutRst;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_SHORT_DELAY: cfg_q.short_delay <= cfg_data;
				REG_LONG_DELAY: cfg_q.long_delay <= cfg_data;
				REG_SAMPLE_HOLD: cfg_q.sample_hold <= cfg_data;
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	i2cbe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(item),
		.item_avail(item_avail),
		.item_take(item_take)
	);

	i2cbe_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item(item),
		.item_avail(item_avail),
		.item_take(item_take),
		.res(res)
	);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the I2C master bit engine: directed ticks, then random command streams.
`timescale 1ns / 1ps

module tb;
	import i2cbe_pkg::*;

	localparam res_t ResIdle = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
	localparam res_t ResStartTaken = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

	typedef struct packed {
		item_t tick;
		logic [9:0] reps;
		logic typed;
		res_t want;
	} tick_row_t;

	typedef struct packed {
		cfg_t regs;
		logic [10:0] ticks;
		logic idle_on;
		logic long_hold;
	} run_plan_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [DataW-1:0] cfg_data;

	i2cbe_cmd_if cmd_ch ();
	i2cbe_res_if res_ch ();

	i2c_master_bit_engine_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	tick_row_t directed_ticks [25] = '{
		'{'{1'b0, OP_START, 8'h00, 1'b1}, 10'd1, 1'b1, ResIdle},
		'{'{1'b1, OpReserved, 8'hFF, 1'b1}, 10'd1, 1'b1, ResIdle},
		'{'{1'b1, OP_START, 8'h00, 1'b1}, 10'd1, 1'b1, ResStartTaken},
		'{'{1'b0, OP_START, 8'h00, 1'b1}, 10'd10, 1'b0, '0},
		'{'{1'b1, OP_WRITE, 8'hFF, 1'b0}, 10'd1, 1'b0, '0},
		'{'{1'b1, OP_WRITE, 8'h00, 1'b1}, 10'd4, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b0}, 10'd60, 1'b0, '0},
		'{'{1'b1, OP_WRITE, 8'h00, 1'b1}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'hFF, 1'b1}, 10'd60, 1'b0, '0},
		'{'{1'b1, OP_WAIT_ACK, 8'h00, 1'b0}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b0}, 10'd10, 1'b0, '0},
		'{'{1'b1, OP_READ, 8'h00, 1'b1}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b1}, 10'd60, 1'b0, '0},
		'{'{1'b1, OP_READ, 8'hFF, 1'b0}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b0}, 10'd60, 1'b0, '0},
		'{'{1'b1, OP_ACK, 8'h00, 1'b0}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b0}, 10'd6, 1'b0, '0},
		'{'{1'b1, OP_NACK, 8'h00, 1'b0}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b0}, 10'd6, 1'b0, '0},
		'{'{1'b1, OP_WAIT_ACK, 8'h00, 1'b1}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b1}, 10'd270, 1'b0, '0},
		'{'{1'b1, OP_WAIT_ACK, 8'h00, 1'b0}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b0}, 10'd10, 1'b0, '0},
		'{'{1'b1, OP_STOP, 8'h00, 1'b0}, 10'd1, 1'b0, '0},
		'{'{1'b0, OP_STOP, 8'h00, 1'b0}, 10'd16, 1'b0, '0}
	};

	cfg_t cur_cfg;
	phase_t eng_phase;
	logic [DataW-1:0] eng_wait;
	logic [DataW-1:0] shreg;
	logic [DataW-1:0] high_polls;
	logic [DataW-1:0] rx_last;
	logic [BitCntW-1:0] bits_done;
	logic bus_scl;
	logic bus_sda;
	logic bus_drive;
	logic ack_lost;

	res_t pending_bus_states [$];
	int unsigned mismatch_count = 0;
	int unsigned ack_release_at = 0;
	logic idle_on = 1'b1;
	logic long_hold_req = 1'b0;

	function automatic void set_hold(logic [DataW-1:0] d, phase_t nxt);
		eng_wait = (d == '0) ? 8'd1 : d;
		eng_phase = nxt;
	endfunction

	function automatic void begin_stop_seq();
		bus_drive = 1'b1;
		bus_sda = 1'b0;
		set_hold(cur_cfg.long_delay, PH_STO1);
	endfunction

	function automatic void shift_out_bit();
		bus_sda = shreg[7];
		shreg = {shreg[6:0], 1'b0};
		bits_done = bits_done + 4'd1;
		set_hold(cur_cfg.short_delay, PH_WRHI);
	endfunction

	function automatic void drop_scl_for_read();
		bus_scl = 1'b0;
		set_hold(cur_cfg.short_delay, PH_RDHI);
	endfunction

	function automatic logic advance_phase(logic sda);
		advance_phase = 1'b0;
		case (eng_phase)
			PH_STA1: begin
				bus_sda = 1'b0;
				set_hold(cur_cfg.long_delay, PH_STA2);
			end
			PH_STA2: begin
				bus_scl = 1'b0;
				advance_phase = 1'b1;
			end
			PH_STO1: begin
				bus_scl = 1'b1;
				set_hold(cur_cfg.long_delay, PH_STO2);
			end
			PH_STO2: begin
				bus_sda = 1'b1;
				set_hold(cur_cfg.long_delay, PH_STO3);
			end
			PH_STO3: advance_phase = 1'b1;
			PH_POLL: begin
				if (!sda) begin
					bus_scl = 1'b0;
					set_hold(cur_cfg.short_delay, PH_WAEND);
				end else if (high_polls >= cur_cfg.ack_timeout) begin
					ack_lost = 1'b1;
					begin_stop_seq();
				end else begin
					high_polls = high_polls + 8'd1;
				end
			end
			PH_WAEND: advance_phase = 1'b1;
			PH_AK1: begin
				bus_scl = 1'b1;
				set_hold(cur_cfg.short_delay, PH_AK2);
			end
			PH_AK2: begin
				bus_scl = 1'b0;
				advance_phase = 1'b1;
			end
			PH_WRHI: begin
				bus_scl = 1'b1;
				set_hold(cur_cfg.short_delay, PH_WRLO);
			end
			PH_WRLO: begin
				bus_scl = 1'b0;
				set_hold(cur_cfg.short_delay, PH_WRNEXT);
			end
			PH_WRNEXT: begin
				if (bits_done >= BitsPerByte) advance_phase = 1'b1;
				else shift_out_bit();
			end
			PH_RDHI: begin
				bus_scl = 1'b1;
				shreg = {shreg[6:0], sda};
				bits_done = bits_done + 4'd1;
				set_hold(cur_cfg.sample_hold, PH_RDNEXT);
			end
			PH_RDNEXT: begin
				if (bits_done >= BitsPerByte) begin
					rx_last = shreg;
					advance_phase = 1'b1;
				end else begin
					drop_scl_for_read();
				end
			end
			default: advance_phase = 1'b1;
		endcase
	endfunction

	function automatic res_t step_bit_engine(item_t it);
		logic done;
		done = 1'b0;
		if (eng_phase == PH_IDLE) begin
			if (it.cmd_ok && it.opcode != OpReserved) begin
				bits_done = '0;
				case (op_t'(it.opcode))
					OP_START: begin
						bus_drive = 1'b1;
						bus_scl = 1'b1;
						bus_sda = 1'b1;
						set_hold(cur_cfg.long_delay, PH_STA1);
					end
					OP_STOP: begin_stop_seq();
					OP_WRITE: begin
						bus_drive = 1'b1;
						bus_scl = 1'b0;
						shreg = it.tx_byte;
						shift_out_bit();
					end
					OP_READ: begin
						bus_drive = 1'b0;
						shreg = '0;
						drop_scl_for_read();
					end
					OP_ACK, OP_NACK: begin
						bus_scl = 1'b0;
						bus_drive = 1'b1;
						bus_sda = (it.opcode == OP_NACK);
						set_hold(cur_cfg.short_delay, PH_AK1);
					end
					default: begin
						bus_drive = 1'b0;
						bus_scl = 1'b1;
						high_polls = '0;
						ack_lost = 1'b0;
						set_hold(cur_cfg.short_delay, PH_POLL);
					end
				endcase
			end
		end else if (eng_phase == PH_POLL) begin
			done = advance_phase(it.sda_in);
		end else if (eng_wait > 8'd1) begin
			eng_wait = eng_wait - 8'd1;
		end else begin
			eng_wait = '0;
			done = advance_phase(it.sda_in);
		end
		if (done) eng_phase = PH_IDLE;
		step_bit_engine = '{bus_scl, bus_sda, bus_drive, eng_phase != PH_IDLE, done, rx_last,
			ack_lost};
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t make_tick(logic allow_cmd);
		item_t t;
		t.tx_byte = 8'($urandom);
		t.opcode = 3'($urandom_range(0, 7));
		t.sda_in = 1'($urandom_range(0, 1));
		if (eng_phase == PH_IDLE) begin
			t.cmd_ok = allow_cmd && ($urandom_range(0, 9) != 0);
			if (t.cmd_ok && t.opcode == OP_WAIT_ACK) begin
				case ($urandom_range(0, 7))
					4: ack_release_at = 32'(cur_cfg.ack_timeout);
					5: ack_release_at = 32'(cur_cfg.ack_timeout) + 32'd1;
					6: ack_release_at = $urandom_range(0, cur_cfg.ack_timeout);
					7: ack_release_at = 1000;
					default: ack_release_at = $urandom_range(0, 3);
				endcase
			end
		end else begin
			t.cmd_ok = ($urandom_range(0, 3) == 0);
			if (eng_phase == PH_POLL) t.sda_in = (32'(high_polls) < ack_release_at);
		end
		return t;
	endfunction

	task automatic push_tick(item_t it, logic typed, res_t typed_res);
		int unsigned gap;
		res_t predicted;
		gap = idle_len();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd_valid <= it.cmd_ok;
		cmd_ch.opcode <= it.opcode;
		cmd_ch.tx_byte <= it.tx_byte;
		cmd_ch.sda_in <= it.sda_in;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		predicted = step_bit_engine(it);
		pending_bus_states.push_back(typed ? typed_res : predicted);
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (pending_bus_states.size() != 0) @(posedge clk);
	endtask

	task automatic cmp_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_bus_states.size() == 0) begin
				$error("result transfer with no expectation pending");
				mismatch_count++;
			end else begin
				want = pending_bus_states.pop_front();
				cmp_field("scl_level", 8'(want.scl_level), 8'(res_ch.scl_level));
				cmp_field("sda_level", 8'(want.sda_level), 8'(res_ch.sda_level));
				cmp_field("sda_drive", 8'(want.sda_drive), 8'(res_ch.sda_drive));
				cmp_field("busy_res", 8'(want.busy_res), 8'(res_ch.busy_res));
				cmp_field("done_res", 8'(want.done_res), 8'(res_ch.done_res));
				cmp_field("rx_byte", want.rx_byte, res_ch.rx_byte);
				cmp_field("ack_missing", 8'(want.ack_missing), 8'(res_ch.ack_missing));
			end
		end
	end

	initial begin
		int unsigned stall;
		stall = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = 400;
			end else if (stall == 0) begin
				stall = idle_len();
			end
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		run_plan_t plans [6];
		plans[0] = '{'{8'd1, 8'd1, 8'd1, 8'd1}, 11'd100, 1'b0, 1'b0};
		plans[1] = '{'{8'd0, 8'd0, 8'd0, 8'd0}, 11'd100, 1'b1, 1'b1};
		plans[2] = '{'{8'd3, 8'd5, 8'd2, 8'd6}, 11'd150, 1'b1, 1'b0};
		plans[3] = '{'{8'd1, 8'd1, 8'd1, 8'd255}, 11'd150, 1'b1, 1'b0};
		plans[4] = '{'{8'd1, 8'd2, 8'd4, 8'd3}, 11'd150, 1'b1, 1'b0};
		plans[5] = '{'{8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
			8'($urandom_range(1, 6)), 8'($urandom_range(1, 6))}, 11'd150, 1'b1, 1'b1};

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd_valid = 1'b0;
		cmd_ch.opcode = OP_START;
		cmd_ch.tx_byte = '0;
		cmd_ch.sda_in = 1'b1;
		cfg_wr_en = 1'b0;
		cfg_index = REG_SHORT_DELAY;
		cfg_data = '0;

		cur_cfg = '{ShortDelayRst, LongDelayRst, SampleHoldRst, AckTimeoutRst};
		eng_phase = PH_IDLE;
		eng_wait = '0;
		bits_done = '0;
		shreg = '0;
		high_polls = '0;
		bus_scl = 1'b1;
		bus_sda = 1'b1;
		bus_drive = 1'b1;
		rx_last = '0;
		ack_lost = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_ticks[i])
			repeat (directed_ticks[i].reps)
				push_tick(directed_ticks[i].tick, directed_ticks[i].typed,
					directed_ticks[i].want);

		foreach (plans[p]) begin
			drain_results();
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_SHORT_DELAY;
			cfg_data <= plans[p].regs.short_delay;
			@(posedge clk);
			cfg_index <= REG_LONG_DELAY;
			cfg_data <= plans[p].regs.long_delay;
			@(posedge clk);
			cfg_index <= REG_SAMPLE_HOLD;
			cfg_data <= plans[p].regs.sample_hold;
			@(posedge clk);
			cfg_index <= REG_ACK_TIMEOUT;
			cfg_data <= plans[p].regs.ack_timeout;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			cur_cfg = plans[p].regs;
			idle_on = plans[p].idle_on;
			if (plans[p].long_hold) long_hold_req = 1'b1;
			repeat (plans[p].ticks) push_tick(make_tick(1'b1), 1'b0, '0);
			while (eng_phase != PH_IDLE) push_tick(make_tick(1'b0), 1'b0, '0);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
